FILE: hw/rtl/spmv_pkg.sv
// spmv_pkg: shared types and constants for the symmetric sparse complex spmv block
// holds the request/response transaction structs, command codes, controller states
// and the controller/datapath command and status structs; depends on nothing
package spmv_pkg;

    // fixed field widths
    localparam int VAL_W = 32;
    localparam int IDX_W = 10;
    localparam int CNT_W = 11;
    localparam int ACC_W = 48;

    // configuration register indexes
    localparam logic CFG_BLOCK_COUNT   = 1'b0;
    localparam logic CFG_TRANSPOSE     = 1'b1;
    localparam int   CFG_DATA_W        = CNT_W;
    localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = 11'd1024;

    // response status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD_X  = 2'd0,
        CMD_DIAG    = 2'd1,
        CMD_OFFDIAG = 2'd2,
        CMD_READ_Y  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                    command;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value_re;
        logic signed [VAL_W-1:0] value_im;
        logic                    is_complex;
    } req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_re;
        logic signed [VAL_W-1:0] result_im;
        logic [IDX_W-1:0]        result_row;
        logic [1:0]              status;
    } rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_RD_A,
        S_MUL_A,
        S_ADD_A,
        S_RD_B,
        S_MUL_B,
        S_ADD_B,
        S_Y_RD,
        S_Y_CLR,
        S_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic ready;     // request channel may take a transaction
        logic latch;     // capture the accepted request
        logic clr_we;    // zero one y entry of the reset sweep
        logic x_we;      // store x entry
        logic mac_rd;    // read x[src] and y[dst]
        logic mul_en;    // register the partial products
        logic acc_we;    // write accumulated y[dst]
        logic pass_b;    // second half of an off-diagonal entry
        logic y_rd;      // read y[row] for a read-and-clear
        logic y_zero;    // clear y[row]
        logic emit;      // load the response register
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        cmd_t cmd;
        logic bad;
        logic clr_last;
        logic out_free;
    } sts_t;

endpackage

FILE: hw/rtl/spmv_ram.sv
// spmv_ram: generic single-write, single-read ram with registered read data
// parameters WIDTH and DEPTH; no dependencies
module spmv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/spmv_ctrl.sv
// spmv_ctrl: sequencing state machine for the spmv block
// depends on spmv_pkg (state_t, ctl_t, sts_t, cmd_t)
module spmv_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  spmv_pkg::sts_t    sts,
    output spmv_pkg::ctl_t    ctl
);

    spmv_pkg::state_t state_reg;
    spmv_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spmv_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            spmv_pkg::S_CLEAR:
            begin
                ctl.clr_we = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = spmv_pkg::S_IDLE;
                end
            end
            spmv_pkg::S_IDLE:
            begin
                ctl.ready = 1'b1;
                if (req_valid)
                begin
                    ctl.latch  = 1'b1;
                    state_next = spmv_pkg::S_DISPATCH;
                end
            end
            spmv_pkg::S_DISPATCH:
            begin
                if (sts.bad)
                begin
                    state_next = spmv_pkg::S_EMIT;
                end
                else
                begin
                    unique case (sts.cmd)
                        spmv_pkg::CMD_LOAD_X:
                        begin
                            ctl.x_we   = 1'b1;
                            state_next = spmv_pkg::S_IDLE;
                        end
                        spmv_pkg::CMD_DIAG,
                        spmv_pkg::CMD_OFFDIAG:
                        begin
                            state_next = spmv_pkg::S_RD_A;
                        end
                        spmv_pkg::CMD_READ_Y:
                        begin
                            state_next = spmv_pkg::S_Y_RD;
                        end
                    endcase
                end
            end
            spmv_pkg::S_RD_A:
            begin
                ctl.mac_rd = 1'b1;
                state_next = spmv_pkg::S_MUL_A;
            end
            spmv_pkg::S_MUL_A:
            begin
                ctl.mul_en = 1'b1;
                state_next = spmv_pkg::S_ADD_A;
            end
            spmv_pkg::S_ADD_A:
            begin
                ctl.acc_we = 1'b1;
                if (sts.cmd == spmv_pkg::CMD_OFFDIAG)
                begin
                    state_next = spmv_pkg::S_RD_B;
                end
                else
                begin
                    state_next = spmv_pkg::S_IDLE;
                end
            end
            spmv_pkg::S_RD_B:
            begin
                ctl.pass_b = 1'b1;
                ctl.mac_rd = 1'b1;
                state_next = spmv_pkg::S_MUL_B;
            end
            spmv_pkg::S_MUL_B:
            begin
                ctl.pass_b = 1'b1;
                ctl.mul_en = 1'b1;
                state_next = spmv_pkg::S_ADD_B;
            end
            spmv_pkg::S_ADD_B:
            begin
                ctl.pass_b = 1'b1;
                ctl.acc_we = 1'b1;
                state_next = spmv_pkg::S_IDLE;
            end
            spmv_pkg::S_Y_RD:
            begin
                ctl.y_rd   = 1'b1;
                state_next = spmv_pkg::S_Y_CLR;
            end
            spmv_pkg::S_Y_CLR:
            begin
                ctl.y_zero = 1'b1;
                state_next = spmv_pkg::S_EMIT;
            end
            spmv_pkg::S_EMIT:
            begin
                if (sts.out_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = spmv_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spmv_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/spmv_dp.sv
// spmv_dp: datapath of the spmv block: x and y stores, multipliers, accumulate,
// read saturation, configuration registers and response register
// depends on spmv_pkg and spmv_ram
module spmv_dp #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  spmv_pkg::ctl_t                    ctl,
    output spmv_pkg::sts_t                    sts,
    input  spmv_pkg::req_t                    req,
    input  logic                              cfg_write,
    input  logic                              cfg_index,
    input  logic [spmv_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output spmv_pkg::rsp_t                    rsp
);

    localparam int AW    = $clog2(MAX_BLOCKS);
    localparam int LIM_W = ($clog2(MAX_BLOCKS + 1) > spmv_pkg::CNT_W) ?
                           $clog2(MAX_BLOCKS + 1) : spmv_pkg::CNT_W;
    localparam int VW    = spmv_pkg::VAL_W;
    localparam int AccW  = spmv_pkg::ACC_W;
    localparam int PW    = 2 * VW + 1;
    localparam int SUM_W = AccW + 2;

    localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'((64'sd1 <<< (AccW - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] ACC_MIN = SUM_W'(-(64'sd1 <<< (AccW - 1)));
    localparam logic signed [AccW-1:0]  V_MAX   = AccW'((64'sd1 <<< (VW - 1)) - 64'sd1);
    localparam logic signed [AccW-1:0]  V_MIN   = AccW'(-(64'sd1 <<< (VW - 1)));

    // configuration registers
    logic [spmv_pkg::CNT_W-1:0] block_count_reg;
    logic                       transpose_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= spmv_pkg::BLOCK_COUNT_RST;
            transpose_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                spmv_pkg::CFG_BLOCK_COUNT: block_count_reg <= cfg_data;
                spmv_pkg::CFG_TRANSPOSE:   transpose_reg   <= cfg_data[0];
            endcase
        end
    end

    // range check of the incoming transaction
    logic row_ok;
    logic col_ok;
    logic bad_now;

    assign row_ok  = (LIM_W'(req.row) < LIM_W'(block_count_reg)) &&
                     (LIM_W'(req.row) < LIM_W'(MAX_BLOCKS));
    assign col_ok  = (LIM_W'(req.col) < LIM_W'(block_count_reg)) &&
                     (LIM_W'(req.col) < LIM_W'(MAX_BLOCKS));
    assign bad_now = !row_ok || ((req.command == spmv_pkg::CMD_OFFDIAG) && !col_ok);

    // latched transaction
    spmv_pkg::cmd_t        cmd_reg;
    logic [spmv_pkg::IDX_W-1:0] row_reg;
    logic [spmv_pkg::IDX_W-1:0] col_reg;
    logic signed [VW-1:0]  vr_reg;
    logic signed [VW-1:0]  vi_reg;
    logic                  cplx_reg;
    logic                  bad_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            cmd_reg  <= req.command;
            row_reg  <= req.row;
            col_reg  <= req.col;
            vr_reg   <= req.value_re;
            vi_reg   <= req.value_im;
            cplx_reg <= req.is_complex;
            bad_reg  <= bad_now;
        end
    end

    // reset sweep counter over the y store
    logic [AW-1:0] clr_cnt_reg;
    logic          clr_last;

    assign clr_last = (clr_cnt_reg == AW'(MAX_BLOCKS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (ctl.clr_we && !clr_last)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    // addresses: pass a is y[row] += a*x[src], pass b is y[col] += a*x[row]
    logic [AW-1:0] row_addr;
    logic [AW-1:0] col_addr;
    logic [AW-1:0] src_addr;
    logic [AW-1:0] dst_addr;

    assign row_addr = AW'(row_reg);
    assign col_addr = AW'(col_reg);
    assign dst_addr = ctl.pass_b ? col_addr : row_addr;
    assign src_addr = (ctl.pass_b || (cmd_reg != spmv_pkg::CMD_OFFDIAG)) ? row_addr : col_addr;

    // x store: {re, im}
    logic [2*VW-1:0] x_rdata;

    spmv_ram #(
        .WIDTH (2 * VW),
        .DEPTH (MAX_BLOCKS)
    ) u_x_ram (
        .clk   (clk),
        .we    (ctl.x_we),
        .waddr (row_addr),
        .wdata ({vr_reg, vi_reg}),
        .re    (ctl.mac_rd),
        .raddr (src_addr),
        .rdata (x_rdata)
    );

    // y store: {re, im} accumulators
    logic              y_we;
    logic [AW-1:0]     y_waddr;
    logic [2*AccW-1:0] y_wdata;
    logic [AW-1:0]     y_raddr;
    logic [2*AccW-1:0] y_rdata;
    logic [2*AccW-1:0] acc_word;

    always_comb
    begin
        y_we    = ctl.clr_we || ctl.acc_we || ctl.y_zero;
        y_waddr = row_addr;
        y_wdata = '0;
        priority if (ctl.clr_we)
        begin
            y_waddr = clr_cnt_reg;
        end
        else if (ctl.acc_we)
        begin
            y_waddr = dst_addr;
            y_wdata = acc_word;
        end
        else
        begin
            y_waddr = row_addr;
        end
    end

    assign y_raddr = ctl.y_rd ? row_addr : dst_addr;

    spmv_ram #(
        .WIDTH (2 * AccW),
        .DEPTH (MAX_BLOCKS)
    ) u_y_ram (
        .clk   (clk),
        .we    (y_we),
        .waddr (y_waddr),
        .wdata (y_wdata),
        .re    (ctl.mac_rd || ctl.y_rd),
        .raddr (y_raddr),
        .rdata (y_rdata)
    );

    // entry operand, conjugated in transpose mode
    logic signed [VW:0] ar;
    logic signed [VW:0] ai;
    logic signed [VW-1:0] xr;
    logic signed [VW-1:0] xi;

    assign ar = (VW + 1)'(vr_reg);
    assign ai = transpose_reg ? -((VW + 1)'(vi_reg)) : (VW + 1)'(vi_reg);
    assign xr = x_rdata[2*VW-1:VW];
    assign xi = x_rdata[VW-1:0];

    // products, each floored to q.16 and registered
    logic signed [PW-1:0]   p_rr;
    logic signed [PW-1:0]   p_ii;
    logic signed [PW-1:0]   p_ir;
    logic signed [PW-1:0]   p_ri;
    logic signed [AccW-1:0] rr_reg;
    logic signed [AccW-1:0] ii_reg;
    logic signed [AccW-1:0] ir_reg;
    logic signed [AccW-1:0] ri_reg;

    assign p_rr = ar * xr;
    assign p_ii = ai * xi;
    assign p_ir = ai * xr;
    assign p_ri = ar * xi;

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            rr_reg <= p_rr[AccW+15:16];
            ii_reg <= p_ii[AccW+15:16];
            ir_reg <= p_ir[AccW+15:16];
            ri_reg <= p_ri[AccW+15:16];
        end
    end

    // accumulate with saturation to the accumulator range
    logic signed [SUM_W-1:0] d_re;
    logic signed [SUM_W-1:0] d_im;
    logic signed [SUM_W-1:0] s_re;
    logic signed [SUM_W-1:0] s_im;
    logic signed [AccW-1:0]  y_re;
    logic signed [AccW-1:0]  y_im;
    logic signed [AccW-1:0]  a_re;
    logic signed [AccW-1:0]  a_im;

    assign y_re = y_rdata[2*AccW-1:AccW];
    assign y_im = y_rdata[AccW-1:0];

    always_comb
    begin
        if (cplx_reg)
        begin
            d_re = SUM_W'(rr_reg) - SUM_W'(ii_reg);
            d_im = SUM_W'(ir_reg) + SUM_W'(ri_reg);
        end
        else
        begin
            d_re = SUM_W'(rr_reg);
            d_im = SUM_W'(ri_reg);
        end
        s_re = SUM_W'(y_re) + d_re;
        s_im = SUM_W'(y_im) + d_im;
        priority if (s_re > ACC_MAX)
            a_re = ACC_MAX[AccW-1:0];
        else if (s_re < ACC_MIN)
            a_re = ACC_MIN[AccW-1:0];
        else
            a_re = s_re[AccW-1:0];
        priority if (s_im > ACC_MAX)
            a_im = ACC_MAX[AccW-1:0];
        else if (s_im < ACC_MIN)
            a_im = ACC_MIN[AccW-1:0];
        else
            a_im = s_im[AccW-1:0];
    end

    assign acc_word = {a_re, a_im};

    // read saturation to q16.16
    logic signed [VW-1:0] c_re;
    logic signed [VW-1:0] c_im;
    logic                 sat_re;
    logic                 sat_im;

    always_comb
    begin
        sat_re = 1'b1;
        sat_im = 1'b1;
        priority if (y_re > V_MAX)
            c_re = V_MAX[VW-1:0];
        else if (y_re < V_MIN)
            c_re = V_MIN[VW-1:0];
        else
        begin
            c_re   = y_re[VW-1:0];
            sat_re = 1'b0;
        end
        priority if (y_im > V_MAX)
            c_im = V_MAX[VW-1:0];
        else if (y_im < V_MIN)
            c_im = V_MIN[VW-1:0];
        else
        begin
            c_im   = y_im[VW-1:0];
            sat_im = 1'b0;
        end
    end

    // response register
    spmv_pkg::rsp_t rsp_reg;
    spmv_pkg::rsp_t rsp_next;
    logic           rsp_valid_reg;

    always_comb
    begin
        rsp_next.result_row = row_reg;
        if (bad_reg)
        begin
            rsp_next.result_re = '0;
            rsp_next.result_im = '0;
            rsp_next.status    = spmv_pkg::ST_RANGE;
        end
        else
        begin
            rsp_next.result_re = c_re;
            rsp_next.result_im = c_im;
            rsp_next.status    = (sat_re || sat_im) ? spmv_pkg::ST_SAT : spmv_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // status to the controller
    assign sts.cmd      = cmd_reg;
    assign sts.bad      = bad_reg;
    assign sts.clr_last = clr_last;
    assign sts.out_free = !rsp_valid_reg || !rsp_stall;

endmodule

FILE: hw/rtl/sym_sparse_complex_spmv_top.sv
// sym_sparse_complex_spmv_top: top level of the symmetric sparse complex spmv block
// instantiates spmv_ctrl and spmv_dp; depends on spmv_pkg
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  spmv_pkg::req_t
//   rsp      out        rsp_valid/rsp_stall  spmv_pkg::rsp_t
//   cfg      in         cfg_write            cfg_index, cfg_data
//
// after reset the y store is swept to zero, one entry a cycle, with req_stall high
// throughout (configuration writes are taken during the sweep).
// one transaction at a time, with one multiply-accumulate unit and one read port per
// store: load x writes x; diagonal reads, multiplies and adds; off-diagonal does so
// for y[row] then y[col]; read-and-clear reads, clears, emits; out-of-range emits.
// a response waits in the output register while the next request is taken;
// a request that yields a response holds until that register is free.
module sym_sparse_complex_spmv_top #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  spmv_pkg::req_t                  req,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output spmv_pkg::rsp_t                  rsp,
    input  logic                            cfg_write,
    input  logic                            cfg_index,
    input  logic [spmv_pkg::CFG_DATA_W-1:0] cfg_data
);

    spmv_pkg::ctl_t ctl;
    spmv_pkg::sts_t sts;

    // sequencer
    spmv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .sts       (sts),
        .ctl       (ctl)
    );

    // stores and arithmetic
    spmv_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .req       (req),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    assign req_stall = !ctl.ready;

endmodule

FILE: sim/tb_sym_sparse_complex_spmv_top.sv
// tb_sym_sparse_complex_spmv_top: self-checking testbench for the spmv block
// drives load/entry/read transactions, predicts y reads and range errors, compares responses
// depends on spmv_pkg and sym_sparse_complex_spmv_top
module tb_sym_sparse_complex_spmv_top;

    localparam int     MAX_ROWS = 1024;
    localparam longint ACC_HI   = 64'sd140737488355327;
    localparam longint ACC_LO   = -ACC_HI - 1;
    localparam longint Q_HI     = 64'sd2147483647;
    localparam longint Q_LO     = -64'sd2147483648;

    logic                            clk;
    logic                            rst_n;
    logic                            req_valid;
    logic                            req_stall;
    spmv_pkg::req_t                  req;
    logic                            rsp_valid;
    logic                            rsp_stall;
    spmv_pkg::rsp_t                  rsp;
    logic                            cfg_write;
    logic                            cfg_index;
    logic [spmv_pkg::CFG_DATA_W-1:0] cfg_data;

    // shadow of the block state: x vector, y accumulators, registers
    longint            vec_x_re  [MAX_ROWS];
    longint            vec_x_im  [MAX_ROWS];
    bit                x_loaded  [MAX_ROWS];
    longint            acc_y_re  [MAX_ROWS];
    longint            acc_y_im  [MAX_ROWS];
    int unsigned       active_blocks;
    bit                conj_mode;

    // responses owed by the block, oldest first
    spmv_pkg::rsp_t    pending_y_out[$];
    int unsigned       hot_rows[8];
    int unsigned       send_idle_pct;
    int unsigned       stall_pct;
    int unsigned       errors;

    sym_sparse_complex_spmv_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // run limit
    initial
    begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int unsigned active_limit();
        return (active_blocks < MAX_ROWS) ? active_blocks : MAX_ROWS;
    endfunction

    function automatic longint sat48(input longint v);
        if (v > ACC_HI)
            return ACC_HI;
        if (v < ACC_LO)
            return ACC_LO;
        return v;
    endfunction

    function automatic logic [spmv_pkg::VAL_W-1:0] clamp_q16(input longint v, inout bit clipped);
        if (v > Q_HI)
        begin
            clipped = 1'b1;
            return Q_HI[spmv_pkg::VAL_W-1:0];
        end
        if (v < Q_LO)
        begin
            clipped = 1'b1;
            return Q_LO[spmv_pkg::VAL_W-1:0];
        end
        return v[spmv_pkg::VAL_W-1:0];
    endfunction

    // y[dst] += a * x[src], each product floored to Q16.16 before summing
    function automatic void accumulate_product(input logic [spmv_pkg::IDX_W-1:0] dst,
                                               input logic [spmv_pkg::IDX_W-1:0] src,
                                               input longint ar, input longint ai, input bit cplx);
        longint dr;
        longint di;
        if (cplx)
        begin
            dr = ((ar * vec_x_re[src]) >>> 16) - ((ai * vec_x_im[src]) >>> 16);
            di = ((ai * vec_x_re[src]) >>> 16) + ((ar * vec_x_im[src]) >>> 16);
        end
        else
        begin
            dr = (ar * vec_x_re[src]) >>> 16;
            di = (ar * vec_x_im[src]) >>> 16;
        end
        acc_y_re[dst] = sat48(acc_y_re[dst] + dr);
        acc_y_im[dst] = sat48(acc_y_im[dst] + di);
    endfunction

    // apply one accepted transaction to the shadow state, queue any response
    function automatic void spmv_update(input spmv_pkg::req_t item);
        spmv_pkg::rsp_t out;
        longint         vr;
        longint         vi;
        bit             clipped;
        bit             bad;
        out = '0;
        out.result_row = item.row;
        bad = (32'(item.row) >= active_limit()) ||
              (item.command == spmv_pkg::CMD_OFFDIAG && 32'(item.col) >= active_limit());
        vr = longint'($signed(item.value_re));
        vi = longint'($signed(item.value_im));
        if (conj_mode)
            vi = -vi;
        if (bad)
        begin
            out.status = spmv_pkg::ST_RANGE;
            pending_y_out.push_back(out);
        end
        else
        begin
            case (item.command)
                spmv_pkg::CMD_LOAD_X:
                begin
                    // x keeps its sign as given, conjugation is for matrix entries only
                    vec_x_re[item.row] = vr;
                    vec_x_im[item.row] = longint'($signed(item.value_im));
                    x_loaded[item.row] = 1'b1;
                end
                spmv_pkg::CMD_DIAG:
                    accumulate_product(item.row, item.row, vr, vi, item.is_complex);
                spmv_pkg::CMD_OFFDIAG:
                begin
                    accumulate_product(item.row, item.col, vr, vi, item.is_complex);
                    accumulate_product(item.col, item.row, vr, vi, item.is_complex);
                end
                default:
                begin
                    clipped = 1'b0;
                    out.result_re = clamp_q16(acc_y_re[item.row], clipped);
                    out.result_im = clamp_q16(acc_y_im[item.row], clipped);
                    out.status = clipped ? spmv_pkg::ST_SAT : spmv_pkg::ST_OK;
                    acc_y_re[item.row] = 0;
                    acc_y_im[item.row] = 0;
                    pending_y_out.push_back(out);
                end
            endcase
        end
    endfunction

    function automatic spmv_pkg::req_t make_req(input spmv_pkg::cmd_t cmd,
                                                input int unsigned row, input int unsigned col,
                                                input logic [spmv_pkg::VAL_W-1:0] re,
                                                input logic [spmv_pkg::VAL_W-1:0] im,
                                                input bit cplx);
        spmv_pkg::req_t r;
        r.command    = cmd;
        r.row        = row[spmv_pkg::IDX_W-1:0];
        r.col        = col[spmv_pkg::IDX_W-1:0];
        r.value_re   = re;
        r.value_im   = im;
        r.is_complex = cplx;
        return r;
    endfunction

    // mix of full-range, small and corner Q16.16 values
    function automatic logic [spmv_pkg::VAL_W-1:0] random_q16();
        int unsigned mode;
        mode = $urandom_range(0, 9);
        if (mode < 4)
            return $urandom();
        if (mode < 8)
            return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0001_0000;
            default: return 32'h0000_0000;
        endcase
    endfunction

    function automatic int unsigned pick_index();
        if ($urandom_range(0, 99) < 75)
            return hot_rows[3'($urandom_range(0, 7))];
        return $urandom_range(0, MAX_ROWS - 1);
    endfunction

    // random transaction; entries that would touch an unloaded x become loads
    function automatic spmv_pkg::req_t random_request();
        spmv_pkg::req_t r;
        int unsigned    pick;
        bit             bad;
        bit             needs_load;
        pick = $urandom_range(0, 99);
        r = make_req(spmv_pkg::CMD_READ_Y, pick_index(), pick_index(), random_q16(),
                     random_q16(), 1'($urandom_range(0, 1)));
        if (pick < 25)
            r.command = spmv_pkg::CMD_LOAD_X;
        else if (pick < 45)
            r.command = spmv_pkg::CMD_DIAG;
        else if (pick < 75)
            r.command = spmv_pkg::CMD_OFFDIAG;
        bad = (32'(r.row) >= active_limit()) ||
              (r.command == spmv_pkg::CMD_OFFDIAG && 32'(r.col) >= active_limit());
        needs_load = (r.command == spmv_pkg::CMD_DIAG && !x_loaded[r.row]) ||
                     (r.command == spmv_pkg::CMD_OFFDIAG &&
                      (!x_loaded[r.row] || !x_loaded[r.col]));
        if (!bad && needs_load)
            r.command = spmv_pkg::CMD_LOAD_X;
        return r;
    endfunction

    // send one transaction, with random idle cycles ahead of it
    task automatic issue_request(input spmv_pkg::req_t item);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        spmv_update(item);
    endtask

    // drop valid, wait for every owed response and for the last entry to finish
    task automatic settle_block();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_y_out.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_register(input logic idx,
                                  input logic [spmv_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == spmv_pkg::CFG_BLOCK_COUNT)
            active_blocks = {{(32 - spmv_pkg::CFG_DATA_W){1'b0}}, value};
        else
            conj_mode = value[0];
    endtask

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // corner values, accumulator saturation, read saturation and clear-on-read
    task automatic test_load_and_accumulate();
        write_register(spmv_pkg::CFG_BLOCK_COUNT, 11'd1024);
        write_register(spmv_pkg::CFG_TRANSPOSE, 11'd0);
        issue_request(make_req(spmv_pkg::CMD_LOAD_X, 0, 1023, 32'h7FFF_FFFF, 32'h8000_0000,
                               1'b0));
        issue_request(make_req(spmv_pkg::CMD_LOAD_X, 1023, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                               1'b1));
        issue_request(make_req(spmv_pkg::CMD_LOAD_X, 1, 0, 32'h0001_0000, 32'hFFFF_0000, 1'b0));
        repeat (3)
            issue_request(make_req(spmv_pkg::CMD_DIAG, 0, 0, 32'h8000_0000, 32'h8000_0000,
                                   1'b1));
        issue_request(make_req(spmv_pkg::CMD_OFFDIAG, 0, 1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               1'b1));
        issue_request(make_req(spmv_pkg::CMD_OFFDIAG, 1, 1, 32'h0002_0000, 32'hDEAD_BEEF,
                               1'b0));
        issue_request(make_req(spmv_pkg::CMD_READ_Y, 0, 0, 32'h0, 32'h0, 1'b0));
        issue_request(make_req(spmv_pkg::CMD_READ_Y, 1023, 0, 32'h0, 32'h0, 1'b0));
        issue_request(make_req(spmv_pkg::CMD_READ_Y, 1, 0, 32'h0, 32'h0, 1'b0));
        issue_request(make_req(spmv_pkg::CMD_READ_Y, 0, 0, 32'h0, 32'h0, 1'b0));
    endtask

    // conjugated entries, including the most negative imaginary part
    task automatic test_transpose();
        settle_block();
        write_register(spmv_pkg::CFG_BLOCK_COUNT, 11'd2);
        write_register(spmv_pkg::CFG_TRANSPOSE, 11'd1);
        issue_request(make_req(spmv_pkg::CMD_LOAD_X, 1, 0, 32'h0003_8000, 32'h8000_0000, 1'b1));
        issue_request(make_req(spmv_pkg::CMD_DIAG, 1, 0, 32'h1234_5678, 32'h8000_0000, 1'b1));
        issue_request(make_req(spmv_pkg::CMD_OFFDIAG, 0, 1, 32'hFFFE_0000, 32'h0000_1000,
                               1'b1));
        issue_request(make_req(spmv_pkg::CMD_READ_Y, 1, 0, 32'h0, 32'h0, 1'b0));
        issue_request(make_req(spmv_pkg::CMD_READ_Y, 0, 0, 32'h0, 32'h0, 1'b0));
    endtask

    // rejected rows and columns, zero and oversized block count
    task automatic test_index_range();
        settle_block();
        write_register(spmv_pkg::CFG_TRANSPOSE, 11'd0);
        issue_request(make_req(spmv_pkg::CMD_LOAD_X, 2, 0, 32'h1111_1111, 32'h2222_2222, 1'b0));
        issue_request(make_req(spmv_pkg::CMD_DIAG, 5, 0, 32'h0001_0000, 32'h0, 1'b1));
        issue_request(make_req(spmv_pkg::CMD_OFFDIAG, 1, 3, 32'h0001_0000, 32'h0, 1'b1));
        issue_request(make_req(spmv_pkg::CMD_READ_Y, 1023, 0, 32'h0, 32'h0, 1'b0));
        settle_block();
        write_register(spmv_pkg::CFG_BLOCK_COUNT, 11'd0);
        issue_request(make_req(spmv_pkg::CMD_READ_Y, 0, 0, 32'h0, 32'h0, 1'b0));
        issue_request(make_req(spmv_pkg::CMD_LOAD_X, 0, 0, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1));
        settle_block();
        write_register(spmv_pkg::CFG_BLOCK_COUNT, 11'd2047);
        issue_request(make_req(spmv_pkg::CMD_DIAG, 1023, 0, 32'h0000_8000, 32'hFFFF_8000,
                               1'b1));
        issue_request(make_req(spmv_pkg::CMD_READ_Y, 1023, 0, 32'h0, 32'h0, 1'b0));
    endtask

    task automatic random_phase(input int unsigned blocks, input bit conj,
                                input int unsigned idle, input int unsigned stall,
                                input int unsigned count);
        settle_block();
        write_register(spmv_pkg::CFG_BLOCK_COUNT, blocks[spmv_pkg::CFG_DATA_W-1:0]);
        write_register(spmv_pkg::CFG_TRANSPOSE, {{(spmv_pkg::CFG_DATA_W-1){1'b0}}, conj});
        send_idle_pct = idle;
        stall_pct     = stall;
        foreach (hot_rows[i])
            hot_rows[i] = $urandom_range(0, active_limit() - 1);
        repeat (count)
            issue_request(random_request());
    endtask

    // random traffic under each idling pattern and several register settings
    task automatic test_random_traffic();
        random_phase(1024, 1'b0, 0, 0, 200);
        random_phase(1, 1'b1, 81, 0, 200);
        random_phase(16, 1'b0, 0, 81, 200);
        random_phase(2047, 1'b1, 7, 7, 200);
    endtask

    // response stall
    initial
    begin
        forever
        begin
            @(negedge clk);
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // response check against the oldest owed transaction
    initial
    begin
        spmv_pkg::rsp_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                if (pending_y_out.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, actual %0d %0d %0d %0d",
                             $time, rsp.result_re, rsp.result_im, rsp.result_row,
                             rsp.status);
                    errors++;
                end
                else
                begin
                    want = pending_y_out.pop_front();
                    compare_field("result_re", longint'(want.result_re),
                                  longint'(rsp.result_re));
                    compare_field("result_im", longint'(want.result_im),
                                  longint'(rsp.result_im));
                    compare_field("result_row", longint'(want.result_row),
                                  longint'(rsp.result_row));
                    compare_field("status", longint'(want.status), longint'(rsp.status));
                end
            end
        end
    end

    // main sequence
    initial
    begin
        errors        = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        active_blocks = MAX_ROWS;
        conj_mode     = 1'b0;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        rsp_stall     = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = spmv_pkg::CFG_BLOCK_COUNT;
        cfg_data      = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_load_and_accumulate();
        test_transpose();
        test_index_range();
        test_random_traffic();
        settle_block();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
